>>> hdl/wfm_pkg.sv
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types and constants of the windowed FFT magnitude block.
// ----------------------------------------------------------------------------
package wfm_pkg;

  // Q1.15 value with room for +1.0
  typedef logic signed [16:0] q15_t;

  // Shared divider operand widths
  localparam int NUM_W = 48;
  localparam int DEN_W = 32;

  // Quarter-wave sine polynomial coefficients, Q30
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598668;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026995;
  localparam logic [30:0] SC9 = 31'd172272;

  // Unity in Q1.15
  localparam logic [16:0] ONE_Q15 = 17'd32768;

endpackage

>>> hdl/wfm_ram.sv
// ----------------------------------------------------------------------------
// wfm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module wfm_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/wfm_div.sv
// ----------------------------------------------------------------------------
// wfm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wfm_pkg::NUM_W-1:0] num,
  input  logic [wfm_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [wfm_pkg::NUM_W-1:0] quot,
  output logic [wfm_pkg::DEN_W-1:0] rem
);
  import wfm_pkg::*;

  logic [NUM_W-1:0] nreg;
  logic [DEN_W-1:0] rreg;
  logic [DEN_W-1:0] dreg;
  logic [5:0]       cnt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rreg, nreg[NUM_W-1]};
    qbit  = (trial >= {1'b0, dreg});
  end

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nreg <= num;
        rreg <= '0;
        dreg <= den;
        cnt  <= 6'(NUM_W);
      end else if (cnt != '0) begin
        nreg <= {nreg[NUM_W-2:0], qbit};
        rreg <= qbit ? DEN_W'(trial - {1'b0, dreg}) : DEN_W'(trial);
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = nreg;
  assign rem  = rreg;

endmodule

>>> hdl/wfm_sqrt.sv
// ----------------------------------------------------------------------------
// wfm_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module wfm_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bt;
  logic [5:0]  cnt;
  logic [63:0] trial;

  assign trial = res + bt;

  // Digit-by-digit root, two radicand bits per step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v   <= value;
        res <= '0;
        bt  <= 64'd1 << 62;
        cnt <= 6'd32;
      end else if (cnt != '0) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule

>>> hdl/wfm_sin.sv
// ----------------------------------------------------------------------------
// wfm_sin
// Sine of a 16-bit phase in Q1.15 by a Horner polynomial on one multiplier.
// ----------------------------------------------------------------------------
module wfm_sin (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   phase,
  output logic          done,
  output wfm_pkg::q15_t value
);
  import wfm_pkg::*;

  logic [2:0]  step;
  logic [16:0] x;
  logic        neg;
  logic [17:0] z;
  logic [30:0] t;
  logic [30:0] ma;
  logic [17:0] mb;
  logic [48:0] prod;
  logic [32:0] prod_sh;
  logic [30:0] coef;
  logic [16:0] xb;
  logic [33:0] rr;
  logic [33:0] rq;
  logic [16:0] rcap;

  // Share one multiplier across the polynomial steps
  always_comb begin
    xb      = {1'b0, phase[13:0], 2'b00};
    ma      = (step == 3'd1) ? 31'(x) : t;
    mb      = (step == 3'd1 || step == 3'd6) ? 18'(x) : z;
    prod    = 49'(ma * mb);
    prod_sh = 33'(prod >> 16);
    case (step)
      3'd2:    coef = SC7;
      3'd3:    coef = SC5;
      3'd4:    coef = SC3;
      default: coef = SC1;
    endcase
    rr   = 34'(prod_sh) + 34'd16384;
    rq   = rr >> 15;
    rcap = (rq > 34'(ONE_Q15)) ? ONE_Q15 : rq[16:0];
  end

  // Advance through square, four Horner steps and final scale
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= phase[14] ? (17'd65536 - xb) : xb;
        neg  <= phase[15];
        t    <= SC9;
        step <= 3'd1;
      end else if (step == 3'd1) begin
        z    <= 18'(prod_sh);
        step <= 3'd2;
      end else if (step >= 3'd2 && step <= 3'd5) begin
        t    <= coef - 31'(prod_sh);
        step <= step + 3'd1;
      end else if (step == 3'd6) begin
        value <= neg ? (17'sd0 - signed'(rcap)) : signed'(rcap);
        done  <= 1'b1;
        step  <= '0;
      end
    end
  end

endmodule

>>> hdl/windowed_fft_magnitude.sv
// ----------------------------------------------------------------------------
// windowed_fft_magnitude
// Hann-windowed radix-2 FFT magnitude spectrum of one audio frame.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; the sample with
// frame_last set closes the frame and raises busy until the last result has
// been sent. Processing of a frame of n samples padded to M points runs two
// divides for the mean and window step size, a sine lookup per stored
// sample for the window and a write per zero-padded point, a cosine and a
// sine per twiddle (M-1 twiddles, from the shared sine unit), then
// (M/2)*log2(M) butterflies on the work memory, a magnitude root per
// emitted bin and a normalizing divide per bin when the peak is nonzero.
// Results leave on result_valid, one cycle each, spaced by the divide; the
// receiver cannot stall them. A frame shorter than MIN_FRAME gives one
// result flagged invalid, registered in the ST_SHORT state that follows
// the closing sample.
// ----------------------------------------------------------------------------
module windowed_fft_magnitude #(
  parameter int MAX_POINTS = 1024,
  parameter int MIN_FRAME  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] sample,
  input  logic               frame_last,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  output logic               result_valid,
  output logic [5:0]         bin_index,
  output logic [15:0]        magnitude,
  output logic               frame_valid,
  output logic               result_last
);
  import wfm_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int LW    = $clog2(AW + 1);
  localparam int SUM_W = 17 + AW;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_SHORT   = 5'd1;
  localparam logic [4:0] ST_MEAN    = 5'd2;
  localparam logic [4:0] ST_MEAN_W  = 5'd3;
  localparam logic [4:0] ST_PH      = 5'd4;
  localparam logic [4:0] ST_PH_W    = 5'd5;
  localparam logic [4:0] ST_WIN_RD  = 5'd6;
  localparam logic [4:0] ST_WIN_W   = 5'd7;
  localparam logic [4:0] ST_WIN_MUL = 5'd8;
  localparam logic [4:0] ST_WIN_WR  = 5'd9;
  localparam logic [4:0] ST_TW_C    = 5'd10;
  localparam logic [4:0] ST_TW_CW   = 5'd11;
  localparam logic [4:0] ST_TW_S    = 5'd12;
  localparam logic [4:0] ST_TW_SW   = 5'd13;
  localparam logic [4:0] ST_BF_RA   = 5'd14;
  localparam logic [4:0] ST_BF_RB   = 5'd15;
  localparam logic [4:0] ST_BF_MUL  = 5'd16;
  localparam logic [4:0] ST_BF_SUM  = 5'd17;
  localparam logic [4:0] ST_BF_WA   = 5'd18;
  localparam logic [4:0] ST_BF_WB   = 5'd19;
  localparam logic [4:0] ST_MG_RD   = 5'd20;
  localparam logic [4:0] ST_MG_SQ   = 5'd21;
  localparam logic [4:0] ST_MG_ADD  = 5'd22;
  localparam logic [4:0] ST_MG_W    = 5'd23;
  localparam logic [4:0] ST_NM_RD   = 5'd24;
  localparam logic [4:0] ST_NM_DIV  = 5'd25;
  localparam logic [4:0] ST_NM_W    = 5'd26;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

  logic [4:0]              state;
  logic [6:0]              bin_cfg;
  logic [CW-1:0]           cnt;
  logic signed [SUM_W-1:0] sum;
  logic [CW-1:0]           n;
  logic signed [SUM_W-1:0] fsum;
  logic [LW-1:0]           m_log;
  logic [6:0]              count;
  logic signed [16:0]      mean;
  logic [15:0]             ph_q;
  logic [AW-1:0]           ph_r;
  logic [15:0]             inc_q;
  logic [AW-1:0]           inc_r;
  logic [CW-1:0]           idx;
  logic signed [17:0]      w_val;
  logic signed [16:0]      d_val;
  logic signed [34:0]      wprod;
  logic [LW-1:0]           stage;
  logic [AW-1:0]           kk;
  logic [AW-1:0]           aa;
  q15_t                    tw_re;
  q15_t                    tw_im;
  logic signed [31:0]      a_re;
  logic signed [31:0]      a_im;
  logic signed [48:0]      p0;
  logic signed [48:0]      p1;
  logic signed [48:0]      p2;
  logic signed [48:0]      p3;
  logic signed [49:0]      vr;
  logic signed [49:0]      vi;
  logic [6:0]              mk;
  logic signed [63:0]      sq0;
  logic signed [63:0]      sq1;
  logic [31:0]             peak;

  // Input side
  logic                    accept;
  logic                    stored;
  logic [CW-1:0]           n_new;
  logic signed [SUM_W-1:0] sum_new;
  logic [LW-1:0]           ml_new;

  // Derived loop values
  logic [CW-1:0]           m_pts;
  logic [CW-1:0]           half_c;
  logic [CW-1:0]           len_c;
  logic [AW-1:0]           bb;
  logic [CW-1:0]           a_next;
  logic [AW-1:0]           rev_full;
  logic [AW-1:0]           rev_addr;
  logic [15:0]             tw_ph;
  logic [SUM_W+1:0]        tnum;
  logic [SUM_W+1:0]        tmag;
  logic                    tneg;
  logic [AW:0]             r_sum;
  logic [6:0]              cc;
  logic [CW-1:0]           hm1;
  logic signed [31:0]      win_y;
  logic signed [31:0]      bf_a_re;
  logic signed [31:0]      bf_a_im;
  logic signed [31:0]      bf_b_re;
  logic signed [31:0]      bf_b_im;
  logic signed [31:0]      rd_re;
  logic signed [31:0]      rd_im;
  logic                    mk_last;

  // Memory ports
  logic signed [15:0]      samp_rd;
  logic                    wk_we;
  logic [AW-1:0]           wk_waddr;
  logic [63:0]             wk_wdata;
  logic [AW-1:0]           wk_raddr;
  logic [63:0]             wk_rd;

  // Shared unit ports
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quot;
  logic [DEN_W-1:0]        div_rem;
  logic                    sin_start;
  logic [15:0]             sin_phase;
  logic                    sin_done;
  q15_t                    sin_val;
  logic                    sq_done;
  logic [31:0]             sq_root;

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // Frame accumulation and next power of two
  always_comb begin
    stored  = (cnt < CW'(MAX_POINTS));
    n_new   = stored ? (cnt + CW'(1)) : cnt;
    sum_new = stored ? (sum + SUM_W'(sample)) : sum;
    ml_new  = LW'(AW);
    for (int l = AW; l >= 0; l--) begin
      if ((CW'(1) << l) >= n_new) begin
        ml_new = LW'(l);
      end
    end
  end

  // Loop geometry and addressing
  always_comb begin
    m_pts    = CW'(1) << m_log;
    half_c   = CW'(1) << (stage - LW'(1));
    len_c    = CW'(1) << stage;
    bb       = AW'({1'b0, aa} + half_c);
    a_next   = {1'b0, aa} + len_c;
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = idx[AW-1-b];
    end
    rev_addr = rev_full >> (LW'(AW) - m_log);
    tw_ph    = 16'd0 - (16'(kk) << (5'd16 - 5'(stage)));
    tnum     = {fsum[SUM_W-1], fsum, 1'b0} + (SUM_W+2)'(n);
    tneg     = tnum[SUM_W+1];
    tmag     = tneg ? (~tnum + (SUM_W+2)'(1)) : tnum;
    r_sum    = (AW+1)'(ph_r) + (AW+1)'(inc_r);
    cc       = (bin_cfg < 7'd8) ? 7'd8 : ((bin_cfg > 7'd64) ? 7'd64 : bin_cfg);
    hm1      = (m_pts >> 1) + CW'(1);
    mk_last  = ((mk + 7'd1) == count);
  end

  // Arithmetic from registered operands
  always_comb begin
    rd_re   = signed'(wk_rd[63:32]);
    rd_im   = signed'(wk_rd[31:0]);
    win_y   = sat32((52'(wprod) + 52'sd2) >>> 2);
    bf_a_re = sat32(((52'(a_re) <<< 15) + 52'(vr) + 52'sd32768) >>> 16);
    bf_a_im = sat32(((52'(a_im) <<< 15) + 52'(vi) + 52'sd32768) >>> 16);
    bf_b_re = sat32(((52'(a_re) <<< 15) - 52'(vr) + 52'sd32768) >>> 16);
    bf_b_im = sat32(((52'(a_im) <<< 15) - 52'(vi) + 52'sd32768) >>> 16);
  end

  // Work memory port selection
  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = aa;
    wk_wdata = {bf_a_re, bf_a_im};
    wk_raddr = aa;
    case (state)
      ST_WIN_WR: begin
        wk_we    = 1'b1;
        wk_waddr = rev_addr;
        wk_wdata = {win_y, 32'd0};
      end
      ST_BF_WA: begin
        wk_we = 1'b1;
      end
      ST_BF_WB: begin
        wk_we    = 1'b1;
        wk_waddr = bb;
        wk_wdata = {bf_b_re, bf_b_im};
      end
      ST_BF_RB: begin
        wk_raddr = bb;
      end
      ST_MG_W: begin
        wk_we    = sq_done;
        wk_waddr = AW'(mk);
        wk_wdata = {sq_root, 32'd0};
      end
      ST_MG_RD, ST_NM_RD: begin
        wk_raddr = AW'(mk);
      end
      default: begin
        wk_raddr = aa;
      end
    endcase
  end

  // Shared divider and sine unit requests
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(tmag) + (tneg ? NUM_W'({n, 1'b0} - CW'(1)) : '0);
    div_den   = DEN_W'({n, 1'b0});
    sin_start = 1'b0;
    sin_phase = tw_ph;
    case (state)
      ST_MEAN: begin
        div_start = 1'b1;
      end
      ST_PH: begin
        div_start = 1'b1;
        div_num   = NUM_W'(65536);
        div_den   = DEN_W'(n - CW'(1));
      end
      ST_NM_DIV: begin
        div_start = (peak != '0);
        div_num   = NUM_W'({wk_rd[63:32], 15'd0}) + NUM_W'(peak >> 1);
        div_den   = peak;
      end
      ST_WIN_RD: begin
        sin_start = (idx < n);
        sin_phase = ph_q + 16'd16384;
      end
      ST_TW_C: begin
        sin_start = 1'b1;
        sin_phase = tw_ph + 16'd16384;
      end
      ST_TW_S: begin
        sin_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cfg <= 7'd64;
    end else if (cfg_we) begin
      bin_cfg <= cfg_data;
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      sum          <= '0;
      peak         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (frame_last) begin
              n     <= n_new;
              fsum  <= sum_new;
              m_log <= ml_new;
              cnt   <= '0;
              sum   <= '0;
              state <= (n_new < CW'(MIN_FRAME)) ? ST_SHORT : ST_MEAN;
            end else begin
              cnt <= n_new;
              sum <= sum_new;
            end
          end
        end
        ST_SHORT: begin
          peak         <= '0;
          result_valid <= 1'b1;
          bin_index    <= '0;
          magnitude    <= '0;
          frame_valid  <= 1'b0;
          result_last  <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_MEAN: begin
          count <= (16'(hm1) < 16'(cc)) ? 7'(hm1) : cc;
          state <= ST_MEAN_W;
        end
        ST_MEAN_W: begin
          if (div_done) begin
            mean  <= tneg ? (17'sd0 - signed'(17'(div_quot))) : signed'(17'(div_quot));
            state <= ST_PH;
          end
        end
        ST_PH: begin
          state <= ST_PH_W;
        end
        ST_PH_W: begin
          if (div_done) begin
            inc_q <= div_quot[15:0];
            inc_r <= AW'(div_rem);
            ph_q  <= '0;
            ph_r  <= AW'((n - CW'(1)) >> 1);
            idx   <= '0;
            state <= ST_WIN_RD;
          end
        end
        ST_WIN_RD: begin
          if (idx < n) begin
            state <= ST_WIN_W;
          end else begin
            wprod <= '0;
            state <= ST_WIN_WR;
          end
        end
        ST_WIN_W: begin
          if (sin_done) begin
            w_val <= 18'sd32768 - 18'(sin_val);
            d_val <= 17'(samp_rd) - mean;
            state <= ST_WIN_MUL;
          end
        end
        ST_WIN_MUL: begin
          wprod <= 35'(d_val * w_val);
          state <= ST_WIN_WR;
        end
        ST_WIN_WR: begin
          // Step the window phase by (65536 / (n-1)) with exact remainder
          if (r_sum >= (AW+1)'(n - CW'(1))) begin
            ph_r <= AW'(r_sum - (AW+1)'(n - CW'(1)));
            ph_q <= ph_q + inc_q + 16'd1;
          end else begin
            ph_r <= AW'(r_sum);
            ph_q <= ph_q + inc_q;
          end
          idx <= idx + CW'(1);
          if ((idx + CW'(1)) == m_pts) begin
            stage <= LW'(1);
            kk    <= '0;
            aa    <= '0;
            state <= ST_TW_C;
          end else begin
            state <= ST_WIN_RD;
          end
        end
        ST_TW_C: begin
          state <= ST_TW_CW;
        end
        ST_TW_CW: begin
          if (sin_done) begin
            tw_re <= sin_val;
            state <= ST_TW_S;
          end
        end
        ST_TW_S: begin
          state <= ST_TW_SW;
        end
        ST_TW_SW: begin
          if (sin_done) begin
            tw_im <= sin_val;
            state <= ST_BF_RA;
          end
        end
        ST_BF_RA: begin
          state <= ST_BF_RB;
        end
        ST_BF_RB: begin
          a_re  <= rd_re;
          a_im  <= rd_im;
          state <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          p0    <= 49'(rd_re * tw_re);
          p1    <= 49'(rd_im * tw_im);
          p2    <= 49'(rd_re * tw_im);
          p3    <= 49'(rd_im * tw_re);
          state <= ST_BF_SUM;
        end
        ST_BF_SUM: begin
          vr    <= 50'(p0) - 50'(p1);
          vi    <= 50'(p2) + 50'(p3);
          state <= ST_BF_WA;
        end
        ST_BF_WA: begin
          state <= ST_BF_WB;
        end
        ST_BF_WB: begin
          // Advance group, then twiddle, then stage
          if (a_next >= m_pts) begin
            if (({1'b0, kk} + CW'(1)) == half_c) begin
              if (stage == m_log) begin
                mk    <= '0;
                peak  <= '0;
                state <= ST_MG_RD;
              end else begin
                stage <= stage + LW'(1);
                kk    <= '0;
                aa    <= '0;
                state <= ST_TW_C;
              end
            end else begin
              kk    <= kk + AW'(1);
              aa    <= kk + AW'(1);
              state <= ST_TW_C;
            end
          end else begin
            aa    <= AW'(a_next);
            state <= ST_BF_RA;
          end
        end
        ST_MG_RD: begin
          state <= ST_MG_SQ;
        end
        ST_MG_SQ: begin
          sq0   <= 64'(rd_re * rd_re);
          sq1   <= 64'(rd_im * rd_im);
          state <= ST_MG_ADD;
        end
        ST_MG_ADD: begin
          state <= ST_MG_W;
        end
        ST_MG_W: begin
          if (sq_done) begin
            if (sq_root > peak) begin
              peak <= sq_root;
            end
            if (mk_last) begin
              mk    <= '0;
              state <= ST_NM_RD;
            end else begin
              mk    <= mk + 7'd1;
              state <= ST_MG_RD;
            end
          end
        end
        ST_NM_RD: begin
          state <= ST_NM_DIV;
        end
        ST_NM_DIV: begin
          if (peak == '0) begin
            result_valid <= 1'b1;
            bin_index    <= mk[5:0];
            magnitude    <= '0;
            frame_valid  <= 1'b1;
            result_last  <= mk_last;
            mk           <= mk + 7'd1;
            state        <= mk_last ? ST_IDLE : ST_NM_RD;
          end else begin
            state <= ST_NM_W;
          end
        end
        ST_NM_W: begin
          if (div_done) begin
            result_valid <= 1'b1;
            bin_index    <= mk[5:0];
            magnitude    <= (div_quot > NUM_W'(ONE_Q15)) ? 16'(ONE_Q15) : div_quot[15:0];
            frame_valid  <= 1'b1;
            result_last  <= mk_last;
            mk           <= mk + 7'd1;
            state        <= mk_last ? ST_IDLE : ST_NM_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stored frame samples
  wfm_ram #(.W(16), .D(DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (accept & stored),
    .waddr (cnt[AW-1:0]),
    .wdata (sample),
    .raddr (idx[AW-1:0]),
    .rdata (samp_rd)
  );

  // Complex working data, real part in the upper half
  wfm_ram #(.W(64), .D(DEPTH)) u_work_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .raddr (wk_raddr),
    .rdata (wk_rd)
  );

  wfm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  wfm_sin u_sin (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .phase (sin_phase),
    .done  (sin_done),
    .value (sin_val)
  );

  wfm_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_MG_ADD),
    .value (64'(sq0) + 64'(sq1)),
    .done  (sq_done),
    .root  (sq_root)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the windowed FFT magnitude block. Frames of
// samples are streamed in through the start/busy handshake with random
// idle bursts; a bit-exact software spectrum computes the expected bins of
// each closed frame and a monitor compares every result strobe against it.
// ----------------------------------------------------------------------------
module testbench;
  import wfm_pkg::*;

  localparam int  MAX_PTS   = 1024;
  localparam int  MIN_PTS   = 64;
  localparam int  DRAIN_CYC = 60;
  localparam longint LIMIT  = 4000000;

  // Frame content styles
  typedef enum int {FR_RANDOM, FR_CONST, FR_SQUARE, FR_RAMP} frame_style_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               last;
  } sample_item_t;

  typedef struct {
    logic [5:0]  bin;
    logic [15:0] mag;
    logic        valid;
    logic        last;
  } bin_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] sample = '0;
  logic               frame_last = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic [6:0]         cfg_data = '0;
  logic               result_valid;
  logic [5:0]         bin_index;
  logic [15:0]        magnitude;
  logic               frame_valid;
  logic               result_last;

  sample_item_t pending_q[$];
  bin_result_t  spectrum_q[$];

  // Software copy of the block state
  int unsigned  bins_cfg = 64;
  longint       frame_mem[MAX_PTS];
  longint       frame_sum = 0;
  int unsigned  frame_len = 0;
  longint       fft_re[MAX_PTS];
  longint       fft_im[MAX_PTS];
  longint unsigned bin_mag[64];

  int     mismatches = 0;
  int     bins_checked = 0;
  int     frames_closed = 0;
  int     short_frames = 0;
  int     gap_left = 0;
  bit     quiet = 1'b0;
  longint cycles = 0;

  windowed_fft_magnitude uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample       (sample),
    .frame_last   (frame_last),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .bin_index    (bin_index),
    .magnitude    (magnitude),
    .frame_valid  (frame_valid),
    .result_last  (result_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- math --
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sin(pi/2 * x/65536) in Q1.15
  function automatic longint quarter_wave(longint unsigned x);
    longint unsigned z, t, r;
    z = (x * x) >> 16;
    t = SC9;
    t = SC7 - ((t * z) >> 16);
    t = SC5 - ((t * z) >> 16);
    t = SC3 - ((t * z) >> 16);
    t = SC1 - ((t * z) >> 16);
    r = (((t * x) >> 16) + 16384) >> 15;
    if (r > 32768) r = 32768;
    return longint'(r);
  endfunction

  function automatic longint sine_q15(int unsigned ph);
    int unsigned     q;
    longint unsigned x;
    longint          v;
    ph = ph & 32'hFFFF;
    q  = ph >> 14;
    x  = longint'(ph & 32'h3FFF) << 2;
    if (q[0]) x = 65536 - x;
    v = quarter_wave(x);
    return q[1] ? -v : v;
  endfunction

  function automatic longint cosine_q15(int unsigned ph);
    return sine_q15(ph + 16384);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Bit-reverse, then radix-2 stages whose span doubles every pass
  function automatic void transform(int unsigned m);
    int unsigned i, j, bt, len, half, stp, k, ph, a, b;
    longint      t, wr, wi, vr, vi, ur, ui;
    j = 0;
    for (i = 1; i < m; i++) begin
      bt = m >> 1;
      while ((j & bt) != 0) begin
        j  = j ^ bt;
        bt = bt >> 1;
      end
      j = j ^ bt;
      if (i < j) begin
        t = fft_re[i]; fft_re[i] = fft_re[j]; fft_re[j] = t;
        t = fft_im[i]; fft_im[i] = fft_im[j]; fft_im[j] = t;
      end
    end
    for (len = 2; len <= m; len <<= 1) begin
      half = len >> 1;
      stp  = 65536 / len;
      for (i = 0; i < m; i += len) begin
        for (k = 0; k < half; k++) begin
          ph = (0 - k * stp) & 32'hFFFF;
          wr = cosine_q15(ph);
          wi = sine_q15(ph);
          a  = i + k;
          b  = i + k + half;
          vr = fft_re[b] * wr - fft_im[b] * wi;
          vi = fft_re[b] * wi + fft_im[b] * wr;
          ur = fft_re[a] * 32768;
          ui = fft_im[a] * 32768;
          fft_re[a] = sat32((ur + vr + 32768) >>> 16);
          fft_im[a] = sat32((ui + vi + 32768) >>> 16);
          fft_re[b] = sat32((ur - vr + 32768) >>> 16);
          fft_im[b] = sat32((ui - vi + 32768) >>> 16);
        end
      end
    end
  endfunction

  // Absorb one accepted sample; on frame close, queue the spectrum bins
  function automatic void absorb_sample(sample_item_t it);
    int unsigned     n, m, cnt, i;
    longint          mean, num, den, d, w, y;
    longint unsigned ph, peak, v, e;
    bin_result_t     r;
    if (frame_len < MAX_PTS) begin
      frame_mem[frame_len] = it.smp;
      frame_sum += it.smp;
      frame_len++;
    end
    if (!it.last) return;
    n = frame_len;
    num = 2 * frame_sum + n;
    den = 2 * n;
    frame_len = 0;
    frame_sum = 0;
    frames_closed++;
    if (n < MIN_PTS) begin
      short_frames++;
      r = '{bin: '0, mag: '0, valid: 1'b0, last: 1'b1};
      spectrum_q.insert(spectrum_q.size(), r);
      return;
    end
    mean = (num >= 0) ? num / den : -((-num + den - 1) / den);
    m = 1;
    while (m < n) m <<= 1;
    for (i = 0; i < m; i++) begin
      y = 0;
      if (i < n) begin
        d  = frame_mem[i] - mean;
        ph = (longint'(i) * 65536 + (n - 1) / 2) / (n - 1);
        w  = 32768 - cosine_q15(int'(ph & 16'hFFFF));
        y  = (d * w + 2) >>> 2;
      end
      fft_re[i] = sat32(y);
      fft_im[i] = 0;
    end
    transform(m);
    cnt = bins_cfg;
    if (cnt < 8) cnt = 8;
    if (cnt > 64) cnt = 64;
    if (cnt > m / 2 + 1) cnt = m / 2 + 1;
    peak = 0;
    for (i = 0; i < cnt; i++) begin
      e = longint'(fft_re[i] * fft_re[i]) + longint'(fft_im[i] * fft_im[i]);
      bin_mag[i] = int_sqrt(e);
      if (bin_mag[i] > peak) peak = bin_mag[i];
    end
    for (i = 0; i < cnt; i++) begin
      v = 0;
      if (peak > 0) v = (bin_mag[i] * 32768 + peak / 2) / peak;
      if (v > 32768) v = 32768;
      r.bin   = i[5:0];
      r.mag   = v[15:0];
      r.valid = 1'b1;
      r.last  = (i + 1 == cnt);
      spectrum_q.insert(spectrum_q.size(), r);
    end
  endfunction

  // --------------------------------------------------------------- driver --
  // Hold the item until busy is low, then advance or idle for a burst
  always @(posedge clk) begin
    sample_item_t nxt;
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) begin
        absorb_sample('{smp: sample, last: frame_last});
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        sample     <= nxt.smp;
        frame_last <= nxt.last;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- monitor --
  // Compare each result strobe with the oldest expected bin
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && result_valid) begin
      if (spectrum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: bin %0d mag %0d valid %0b last %0b",
                   $realtime, bin_index, magnitude, frame_valid, result_last);
      end else begin
        want = spectrum_q.pop_front();
        bins_checked++;
        if (bin_index !== want.bin || magnitude !== want.mag ||
            frame_valid !== want.valid || result_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] mismatch: exp bin %0d mag %0d valid %0b last %0b,",
                      " got bin %0d mag %0d valid %0b last %0b"}, $realtime,
                     want.bin, want.mag, want.valid, want.last,
                     bin_index, magnitude, frame_valid, result_last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus --
  task automatic add_frame(int len, frame_style_t style);
    sample_item_t it;
    int           lvl, per;
    lvl = $urandom_range(1, 32767);
    per = $urandom_range(2, 16);
    for (int i = 0; i < len; i++) begin
      case (style)
        FR_RANDOM: it.smp = 16'($urandom);
        FR_CONST:  it.smp = 16'(lvl);
        FR_SQUARE: it.smp = ((i / per) % 2) ? 16'(-lvl) : 16'(lvl);
        default:   it.smp = 16'((i * 997) - 32768);
      endcase
      it.last = (i == len - 1);
      pending_q.insert(pending_q.size(), it);
    end
  endtask

  // Wait until every transaction is sent and every bin has come back
  task automatic drain();
    while (pending_q.size() > 0 || start || busy || spectrum_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_bins(logic [6:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    bins_cfg  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_one(logic signed [15:0] s, logic l);
    sample_item_t it;
    it.smp  = s;
    it.last = l;
    pending_q.insert(pending_q.size(), it);
  endtask

  initial begin
    frame_style_t st;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Short frames: single-sample frames at both extremes, then a few more
    push_one(-16'sd32768, 1'b1);
    push_one(16'sd32767, 1'b1);
    push_one(16'sd32767, 1'b0);
    push_one(-16'sd32768, 1'b1);
    push_one(16'sd0, 1'b0);
    push_one(-16'sd1, 1'b0);
    push_one(16'sd1, 1'b1);
    add_frame(12, FR_RANDOM);
    drain();

    // Bin count below range, smallest padded size
    write_bins(7'd0);
    add_frame(64, FR_RANDOM);
    add_frame($urandom_range(1, 20), FR_RANDOM);
    drain();

    // Bin count above range, frame padded to 128 points
    write_bins(7'd127);
    add_frame(100, FR_SQUARE);
    add_frame($urandom_range(1, 8), FR_RAMP);
    drain();

    // Flat frame gives a zero maximum; bin count just below range
    write_bins(7'd7);
    add_frame(64, FR_CONST);
    drain();

    // Closing stretch with no idling
    write_bins(7'($urandom_range(9, 63)));
    quiet = 1'b1;
    st = frame_style_t'($urandom_range(0, 3));
    add_frame($urandom_range(64, 70), st);
    add_frame($urandom_range(1, 8), FR_RANDOM);
    drain();

    $display("Covered %0d frames (%0d short), %0d bins checked, bin counts 0..127",
             frames_closed, short_frames, bins_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> windowed_fft_magnitude.f
hdl/wfm_pkg.sv
hdl/wfm_ram.sv
hdl/wfm_div.sv
hdl/wfm_sqrt.sv
hdl/wfm_sin.sv
hdl/windowed_fft_magnitude.sv
test/testbench.sv
